// ===== sv/ple_pkg.sv =====
package ple_pkg;

  // list geometry
  localparam int DEPTH = 16;
  localparam int WIDTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 5;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // operation codes
  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_ERASE  = 2'd1;
  localparam logic [1:0] FN_SEARCH = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [31:0]      value;
    logic [POS_W-1:0] position;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [3:0] found_index;
    logic [4:0] element_total;
    logic       is_empty;
  } out_word_t;

  // command broadcast to every cell
  typedef struct packed {
    logic             do_ins;
    logic             do_era;
    logic [WIDTH-1:0] value;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] count;
  } cell_cmd_t;

endpackage

// ===== sv/ple_cell.sv =====
module ple_cell
  import ple_pkg::*;
(
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic [WIDTH-1:0] left_data,
  input  logic [WIDTH-1:0] right_data,
  output logic [WIDTH-1:0] data_r,
  output logic             match
);

  logic [WIDTH-1:0] data_nxt;
  logic [CMP_W-1:0] idx_x;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;

  assign idx_x = CMP_W'(cell_idx);
  assign pos_x = CMP_W'(cmd.pos);
  assign cnt_x = CMP_W'(cmd.count);

  // shift toward tail on insert, toward head on erase
  always_comb begin
    data_nxt = data_r;
    if (cmd.do_ins) begin
      if (idx_x > pos_x) begin
        data_nxt = left_data;
      end else if (idx_x == pos_x) begin
        data_nxt = cmd.value;
      end
    end else if (cmd.do_era) begin
      if (idx_x >= pos_x) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // only occupied cells may match
  assign match = (data_r == cmd.value) && (idx_x < cnt_x);

endmodule

// ===== sv/ple_encoder.sv =====
module ple_encoder
  import ple_pkg::*;
(
  input  logic [DEPTH-1:0] hits,
  output logic             found,
  output logic [IDX_W-1:0] index
);

  // lowest set bit wins
  always_comb begin
    found = |hits;
    index = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (hits[k]) begin
        index = IDX_W'(k);
      end
    end
  end

endmodule

// ===== sv/positional_list_engine.sv =====
// Throughput: one word per cycle while in_stall is low; every cell updates
// in the cycle of acceptance, and the search hit vector is priority encoded
// in the following stage.
// Reset: rst_n synchronous active low clears the element count and valid flags;
// entry storage is not cleared.
module positional_list_engine
  import ple_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             s1_valid_r;
  logic [DEPTH-1:0] s1_hits_r;
  logic [1:0]       s1_status_r;
  logic [CNT_W-1:0] s1_count_r;
  logic             out_valid_r;
  out_word_t        out_data_r;

  logic             out_free, s1_adv, in_acc;
  logic             full, ins_range, era_range;
  logic             ins_ok, era_ok;
  logic [1:0]       status;
  cell_cmd_t        cmd;
  logic [WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0] hits;
  logic             enc_found;
  logic [IDX_W-1:0] enc_index;

  // pipeline flow
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // request checks
  assign full      = (CMP_W'(count_r) >= CMP_W'(DEPTH));
  assign ins_range = (CMP_W'(in_data.position) > CMP_W'(count_r));
  assign era_range = (CMP_W'(in_data.position) >= CMP_W'(count_r));
  assign ins_ok    = in_acc && (in_data.func == FN_INSERT) && !full && !ins_range;
  assign era_ok    = in_acc && (in_data.func == FN_ERASE) && !era_range;

  always_comb begin
    case (in_data.func)
      FN_INSERT: status = full ? ST_FULL : (ins_range ? ST_RANGE : ST_OK);
      FN_ERASE:  status = era_range ? ST_RANGE : ST_OK;
      default:   status = ST_OK;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (era_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // command broadcast
  assign cmd.do_ins = ins_ok;
  assign cmd.do_era = era_ok;
  assign cmd.value  = in_data.value[WIDTH-1:0];
  assign cmd.pos    = in_data.position;
  assign cmd.count  = count_r;

  // cell chain
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WIDTH-1:0] left_d, right_d;
    if (k == 0) begin : g_head
      assign left_d = cmd.value;
    end else begin : g_mid_l
      assign left_d = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_tail
      assign right_d = cell_data[k];
    end else begin : g_mid_r
      assign right_d = cell_data[k+1];
    end
    ple_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cell_idx   (IDX_W'(k)),
      .left_data  (left_d),
      .right_data (right_d),
      .data_r     (cell_data[k]),
      .match      (hits[k])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // stage one payload: hits only count for a search
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_hits_r   <= (in_data.func == FN_SEARCH) ? hits : '0;
      s1_status_r <= status;
      s1_count_r  <= count_nxt;
    end
  end

  ple_encoder u_enc (
    .hits  (s1_hits_r),
    .found (enc_found),
    .index (enc_index)
  );

  // output word
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.status        <= s1_status_r;
      out_data_r.found         <= enc_found;
      out_data_r.found_index   <= 4'(enc_index);
      out_data_r.element_total <= 5'(s1_count_r);
      out_data_r.is_empty      <= (s1_count_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
